// File: design/ept_pkg.sv
`default_nettype none

package ept_pkg;

  // Default width of the internal counts
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration register widths and reset values
  localparam int CPR_W     = 11;
  localparam int DIVCFG_W  = 5;
  localparam int POS_W     = 10;
  localparam int FIELD_W   = 16;
  localparam int FUNC_W    = 2;
  localparam int ADDR_W    = 2;

  localparam logic [CPR_W-1:0]    CPR_RESET = 11'd24;
  localparam logic [CPR_W-1:0]    CPR_MAX   = 11'd1024;
  localparam logic [DIVCFG_W-1:0] DIV_RESET = 5'd2;

  // Register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_CPR = 2'd0;
  localparam logic [ADDR_W-1:0] REG_DIV = 2'd1;
  localparam logic [ADDR_W-1:0] REG_REV = 2'd2;

  // Function selector codes (code 3 behaves as a plain reading)
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ZERO  = 2'd2;

  // Handshake between the sequencer and the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: design/encoder_position_tracker_unit.sv
`default_nettype none

// Rotary encoder position tracker. Each input word carries a raw signed counter
// reading (tdata) and a function code (tuser: 0 reading, 1 reading plus delta
// query, 2 clear all tracking state, 3 same as 0). The reading is divided by
// count_divider (toward zero), differenced against the previous scaled reading,
// optionally negated, and accumulated; position within a revolution and turns
// follow by floored division by counts_per_rev. Both divisions run on one
// shared radix-4 divider of width DW, the even value of max(COUNT_WIDTH,11)+1
// and at least 16 (18 at COUNT_WIDTH 16). A reading passes through the
// first division, the second division and the finish state; its result is
// registered on leaving the finish state, and the next word can be taken in
// the same cycle that the result shows. A clear goes straight to the finish state.
// One word is in flight at a time; a new word is taken while the last result
// waits on the output, and a result still waiting when the next one is ready
// stalls the block. Configuration writes must happen while idle.
module encoder_position_tracker_unit #(
  parameter int COUNT_WIDTH = ept_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input words
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [15:0]                      in_tdata,  // [15:0] raw_reading
  input  wire logic [ept_pkg::FUNC_W-1:0]       in_tuser,  // [1:0] func
  // result words
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] total_count, [25:16] rev_position, [41:26] turns, [57:42] change
  output logic [63:0]                           out_tdata,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [ept_pkg::ADDR_W-1:0]       cfg_addr,
  input  wire logic [ept_pkg::CPR_W-1:0]        cfg_wdata
);

  localparam int CW  = COUNT_WIDTH;
  localparam int SW  = ((CW > 11) ? CW : 11) + 1;
  localparam int DWR = (SW > 16) ? SW : 16;
  localparam int DW  = DWR + (DWR % 2);
  localparam int PW  = ept_pkg::POS_W;
  localparam int FW  = ept_pkg::FIELD_W;
  localparam int RW  = ept_pkg::CPR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_DIV2 = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // configuration
  logic [RW-1:0]                   cpr_r;
  logic [ept_pkg::DIVCFG_W-1:0]    divcfg_r;
  logic                            rev_r;

  // tracking state
  logic signed [CW-1:0] last_scaled_r;
  logic signed [CW-1:0] running_count_r;
  logic [PW-1:0]        position_r;
  logic signed [CW-1:0] turn_count_r;
  logic signed [CW-1:0] delta_base_r;

  // per-word context
  logic [ept_pkg::FUNC_W-1:0] func_r;
  logic                       raw_neg_r;
  logic                       s_neg_r;
  logic signed [CW-1:0]       change_r;

  // output register
  logic          out_valid_r;
  logic [63:0]   out_data_r;

  // divider hookup
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [RW-1:0]     div_divisor;
  ept_pkg::div_stat_t div_stat;
  logic [DW-1:0]     div_quot;
  logic [RW-1:0]     div_rem;

  logic          accept;
  logic [RW-1:0] cpr_eff;
  logic [RW-1:0] div_eff;
  logic [15:0]   raw_mag;

  logic [DW-1:0]        scaled_v;
  logic signed [CW-1:0] d_v;
  logic signed [CW-1:0] rc_v;
  logic signed [SW-1:0] s_v;
  logic [SW-1:0]        s_mag;
  logic [DW-1:0]        q_v;
  logic [RW-1:0]        r_v;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Clamp the configuration into its usable range
  always_comb begin
    if (cpr_r == '0) begin
      cpr_eff = RW'(1);
    end else if (cpr_r > ept_pkg::CPR_MAX) begin
      cpr_eff = ept_pkg::CPR_MAX;
    end else begin
      cpr_eff = cpr_r;
    end
    div_eff = (divcfg_r == '0) ? RW'(1) : RW'(divcfg_r);
  end

  assign raw_mag = in_tdata[15] ? (16'd0 - in_tdata) : in_tdata;

  // After the first division: scale, difference, accumulate, fold operand
  always_comb begin
    scaled_v = raw_neg_r ? (DW'(0) - div_quot) : div_quot;
    d_v      = scaled_v[CW-1:0] - last_scaled_r;
    if (rev_r) begin
      d_v = -d_v;
    end
    rc_v  = running_count_r + d_v;
    s_v   = SW'(d_v) + SW'(position_r);
    s_mag = s_v[SW-1] ? (SW'(0) - s_v) : s_v;
  end

  // After the second division: floored quotient and remainder
  always_comb begin
    if (!s_neg_r) begin
      q_v = div_quot;
      r_v = div_rem;
    end else if (div_rem == '0) begin
      q_v = DW'(0) - div_quot;
      r_v = '0;
    end else begin
      q_v = ~div_quot;
      r_v = cpr_eff - div_rem;
    end
  end

  // Divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(raw_mag);
    div_divisor  = div_eff;
    if (state_r == ST_IDLE) begin
      div_start = accept && (in_tuser != ept_pkg::FUNC_ZERO);
    end else begin
      div_start    = (state_r == ST_DIV1) && div_stat.done;
      div_dividend = DW'(s_mag);
      div_divisor  = cpr_eff;
    end
  end

  ept_div #(
    .WIDTH (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == ept_pkg::FUNC_ZERO) ? ST_FIN : ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= ept_pkg::CPR_RESET;
      divcfg_r <= ept_pkg::DIV_RESET;
      rev_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ept_pkg::REG_CPR: cpr_r    <= cfg_wdata;
        ept_pkg::REG_DIV: divcfg_r <= cfg_wdata[ept_pkg::DIVCFG_W-1:0];
        ept_pkg::REG_REV: rev_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Tracking state and per-word context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      last_scaled_r   <= '0;
      running_count_r <= '0;
      position_r      <= '0;
      turn_count_r    <= '0;
      delta_base_r    <= '0;
      change_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        func_r    <= in_tuser;
        raw_neg_r <= in_tdata[15];
        if (in_tuser == ept_pkg::FUNC_ZERO) begin
          last_scaled_r   <= '0;
          running_count_r <= '0;
          position_r      <= '0;
          turn_count_r    <= '0;
          delta_base_r    <= '0;
          change_r        <= '0;
        end
      end
      if (state_r == ST_DIV1 && div_stat.done) begin
        last_scaled_r   <= scaled_v[CW-1:0];
        running_count_r <= rc_v;
        s_neg_r         <= s_v[SW-1];
        if (func_r == ept_pkg::FUNC_QUERY) begin
          change_r     <= rc_v - delta_base_r;
          delta_base_r <= rc_v;
        end else begin
          change_r <= '0;
        end
      end
      if (state_r == ST_DIV2 && div_stat.done) begin
        position_r   <= r_v[PW-1:0];
        turn_count_r <= turn_count_r + signed'(q_v[CW-1:0]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {6'd0, FW'(change_r), FW'(turn_count_r), position_r,
                      FW'(running_count_r)};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A delivered position always lies inside the current revolution
  a_pos_in_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (RW'(out_data_r[25:16]) < cpr_eff))
    else $error("rev_position outside revolution");

  // A clear request wipes the accumulated counts at once
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == ept_pkg::FUNC_ZERO) |=>
      (running_count_r == '0 && turn_count_r == '0 && position_r == '0))
    else $error("clear request left state behind");

endmodule

`default_nettype wire

// File: design/ept_div.sv
`default_nettype none

// Unsigned restoring divider, two quotient bits per cycle.
// Divisor is at most 1024 and never zero.
module ept_div #(
  parameter int WIDTH = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [WIDTH-1:0]             dividend,
  input  wire logic [ept_pkg::CPR_W-1:0]    divisor,
  output ept_pkg::div_stat_t                stat,
  output logic      [WIDTH-1:0]             quot,
  output logic      [ept_pkg::CPR_W-1:0]    rem
);

  localparam int HALF  = WIDTH / 2;
  localparam int CNT_W = $clog2(HALF + 1);
  localparam int RW    = ept_pkg::CPR_W;

  logic [WIDTH-1:0] acc_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIDTH-1:0] acc_nxt;
  logic [RW-1:0]    rem_nxt;

  // Two restoring steps per cycle
  always_comb begin
    logic [RW:0] t;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 2; k++) begin
      t = {rem_nxt, acc_nxt[WIDTH-1]};
      acc_nxt = {acc_nxt[WIDTH-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        acc_nxt[0] = 1'b1;
      end
      rem_nxt = t[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      acc_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      cnt_r  <= CNT_W'(HALF);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = acc_r;
  assign rem       = rem_r;

  // Remainder is always reduced when the quotient is handed back
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // The sequencer never restarts a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

`default_nettype wire
